### hw/rtl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants for the vertex transform and projection unit.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int unsigned CoefWords = 19;
  localparam int unsigned HiBase    = 16;
  localparam int unsigned LoBase    = 12;
  localparam int unsigned ZShift    = 15;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned DivSteps  = 64;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_XFORM = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_BOUNDS   = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    DIV_X = 2'd0,
    DIV_Y = 2'd1,
    DIV_Z = 2'd2,
    DIV_NONE = 2'd3
  } div_sel_t;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_MUL      = 6'b000010,
    ST_DIV_INIT = 6'b000100,
    ST_DIV_RUN  = 6'b001000,
    ST_DIV_END  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  localparam logic [31:0] BoxMinReset = 32'h7FFF_FFFF;
  localparam logic [31:0] BoxMaxReset = 32'h8000_0000;

endpackage

### hw/rtl/vertex_transform_project_unit.sv
// ----------------------------------------------------------------------------
// vertex_transform_project_unit
// Transforms 16.16 vertices by a stored 4x4 matrix and projects them to screen.
// ----------------------------------------------------------------------------
// A transformed vertex runs a multiply-accumulate on one shared 32x32
// multiplier and then three passes (x, y, z) of one radix-2 divider, and the
// unit takes no new word until that vertex's result has been loaded into the
// output register; a zero w skips the divider and flags divide_fault.
// Coefficient loads, box clears and skipped vertices are taken in idle.
// Synchronous reset clears the coefficients, offsets, bounds enable and output
// valid, resets the bounding box and returns to idle.
module vertex_transform_project_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // coef_index, coef_value, vertex_x, vertex_y, vertex_z, vertex_used, pad.
  input  logic [135:0] s_axis_tdata,
  // kind.
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // screen_x, screen_y, depth_z, clip_w, bound_min_x, bound_min_y,
  // bound_max_x, bound_max_y.
  output logic [255:0] m_axis_tdata,
  // divide_fault.
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  vtp_pkg::state_t state;
  logic [31:0] coef [vtp_pkg::CoefWords];
  logic [31:0] off_x, off_y;
  logic        bounds_en;
  logic [31:0] box_min_x, box_min_y, box_max_x, box_max_y;
  logic [31:0] vx, vy, vz;
  logic        last_flag;

  logic [1:0]  phase;
  logic [2:0]  k;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] m33;
  logic [31:0] w;
  logic [63:0] sx, sy, sz;

  vtp_pkg::div_sel_t sel;
  logic [63:0] num, den, rem;
  logic        neg;
  logic [5:0]  cnt;
  logic [31:0] res_x, res_y, res_z;
  logic        fault;

  logic        s_fire;
  logic [4:0]  in_idx;
  logic [1:0]  col;
  logic [4:0]  rd_addr;
  logic [31:0] rd_data;
  logic [31:0] mul_b;
  logic [63:0] acc_sum;
  logic [63:0] w64, n_sel;
  logic        is_signed, n_neg;
  logic [64:0] trial;
  logic [63:0] q_fix;
  logic        out_load;
  logic        upd;
  logic [31:0] min_x_next, min_y_next, max_x_next, max_y_next;

  assign s_axis_tready = (state == vtp_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign in_idx        = s_axis_tdata[4:0];
  assign col           = phase + 2'd3;

  always_comb begin
    unique case (k)
      3'd0:    rd_addr = 5'(vtp_pkg::HiBase) + {3'b0, col};
      3'd1:    rd_addr = 5'(vtp_pkg::LoBase) + {3'b0, col};
      3'd2:    rd_addr = {3'b000, col};
      3'd3:    rd_addr = {3'b001, col};
      3'd4:    rd_addr = {3'b010, col};
      default: rd_addr = {3'b010, col};
    endcase
  end
  assign rd_data = coef[rd_addr];

  always_comb begin
    unique case (k)
      3'd2:    mul_b = vx;
      3'd3:    mul_b = vy;
      default: mul_b = vz;
    endcase
  end

  assign acc_sum   = acc + prod;
  assign w64       = {{32{w[31]}}, w};
  assign is_signed = (sel != vtp_pkg::DIV_Z);

  always_comb begin
    unique case (sel)
      vtp_pkg::DIV_X: n_sel = sx;
      vtp_pkg::DIV_Y: n_sel = sy;
      default:        n_sel = {sz[48:0], 15'b0};
    endcase
  end
  assign n_neg = is_signed && n_sel[63];
  assign trial = {rem, num[63]};
  assign q_fix = neg ? (64'd0 - num) : num;

  assign out_load = (state == vtp_pkg::ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign upd      = out_load && !fault && bounds_en;

  always_comb begin
    min_x_next = box_min_x;
    max_x_next = box_max_x;
    min_y_next = box_min_y;
    max_y_next = box_max_y;
    if (upd) begin
      if ($signed(res_x) < $signed(box_min_x)) min_x_next = res_x;
      if ($signed(box_max_x) < $signed(res_x)) max_x_next = res_x;
      if ($signed(res_y) < $signed(box_min_y)) min_y_next = res_y;
      if ($signed(box_max_y) < $signed(res_y)) max_y_next = res_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x     <= '0;
      off_y     <= '0;
      bounds_en <= 1'b0;
    end else if (cfg_valid) begin
      unique case (vtp_pkg::cfg_index_t'(cfg_index))
        vtp_pkg::CFG_OFFSET_X: off_x     <= cfg_data;
        vtp_pkg::CFG_OFFSET_Y: off_y     <= cfg_data;
        vtp_pkg::CFG_BOUNDS:   bounds_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtp_pkg::CoefWords; i++) coef[i] <= '0;
    end else if (s_fire && vtp_pkg::kind_t'(s_axis_tuser) == vtp_pkg::KIND_LOAD &&
                 in_idx < 5'(vtp_pkg::CoefWords)) begin
      coef[in_idx] <= s_axis_tdata[36:5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= vtp_pkg::BoxMinReset;
      box_min_y <= vtp_pkg::BoxMinReset;
      box_max_x <= vtp_pkg::BoxMaxReset;
      box_max_y <= vtp_pkg::BoxMaxReset;
    end else if (s_fire && vtp_pkg::kind_t'(s_axis_tuser) == vtp_pkg::KIND_CLEAR) begin
      box_min_x <= vtp_pkg::BoxMinReset;
      box_min_y <= vtp_pkg::BoxMinReset;
      box_max_x <= vtp_pkg::BoxMaxReset;
      box_max_y <= vtp_pkg::BoxMaxReset;
    end else begin
      box_min_x <= min_x_next;
      box_min_y <= min_y_next;
      box_max_x <= max_x_next;
      box_max_y <= max_y_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vtp_pkg::ST_IDLE;
    end else begin
      unique case (state)
        vtp_pkg::ST_IDLE: begin
          if (s_fire && vtp_pkg::kind_t'(s_axis_tuser) == vtp_pkg::KIND_XFORM &&
              s_axis_tdata[133]) begin
            vx        <= s_axis_tdata[68:37];
            vy        <= s_axis_tdata[100:69];
            vz        <= s_axis_tdata[132:101];
            last_flag <= s_axis_tlast;
            phase     <= 2'd0;
            k         <= 3'd0;
            state     <= vtp_pkg::ST_MUL;
          end
        end
        vtp_pkg::ST_MUL: begin
          unique case (k)
            3'd0: acc <= (col == 2'd3) ? 64'd0 : {rd_data, 32'd0};
            3'd1: begin
              if (col == 2'd3) m33 <= rd_data;
              else acc[31:0] <= rd_data;
            end
            3'd2: prod <= $signed(rd_data) * $signed(mul_b);
            3'd3, 3'd4: begin
              acc  <= acc_sum;
              prod <= $signed(rd_data) * $signed(mul_b);
            end
            default: begin
              unique case (col)
                2'd3: w  <= acc_sum[47:16] + m33;
                2'd0: sx <= acc_sum;
                2'd1: sy <= acc_sum;
                default: sz <= acc_sum;
              endcase
            end
          endcase
          if (k == 3'd5) begin
            k     <= 3'd0;
            phase <= phase + 2'd1;
            if (phase == 2'd3) begin
              sel   <= vtp_pkg::DIV_X;
              state <= vtp_pkg::ST_DIV_INIT;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        vtp_pkg::ST_DIV_INIT: begin
          if (w == 32'd0) begin
            fault <= 1'b1;
            res_x <= '0;
            res_y <= '0;
            res_z <= '0;
            state <= vtp_pkg::ST_DONE;
          end else begin
            fault <= 1'b0;
            num   <= n_neg ? (64'd0 - n_sel) : n_sel;
            den   <= (is_signed && w[31]) ? (64'd0 - w64) : w64;
            neg   <= is_signed && (n_sel[63] ^ w[31]);
            rem   <= '0;
            cnt   <= '0;
            state <= vtp_pkg::ST_DIV_RUN;
          end
        end
        vtp_pkg::ST_DIV_RUN: begin
          if (trial >= {1'b0, den}) begin
            rem <= 64'(trial - {1'b0, den});
            num <= {num[62:0], 1'b1};
          end else begin
            rem <= trial[63:0];
            num <= {num[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(vtp_pkg::DivSteps - 1)) state <= vtp_pkg::ST_DIV_END;
        end
        vtp_pkg::ST_DIV_END: begin
          unique case (sel)
            vtp_pkg::DIV_X: begin
              res_x <= q_fix[31:0] + off_x;
              sel   <= vtp_pkg::DIV_Y;
              state <= vtp_pkg::ST_DIV_INIT;
            end
            vtp_pkg::DIV_Y: begin
              res_y <= q_fix[31:0] + off_y;
              sel   <= vtp_pkg::DIV_Z;
              state <= vtp_pkg::ST_DIV_INIT;
            end
            default: begin
              res_z <= q_fix[31:0];
              state <= vtp_pkg::ST_DONE;
            end
          endcase
        end
        vtp_pkg::ST_DONE: begin
          if (out_load) state <= vtp_pkg::ST_IDLE;
        end
        default: state <= vtp_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {max_y_next, max_x_next, min_y_next, min_x_next,
                        w, res_z, res_y, res_x};
      m_axis_tuser  <= fault;
      m_axis_tlast  <= last_flag;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule
